[src/ots_pkg.sv]
// ----------------------------------------------------------------------------
// Order table snapshot builder: shared definitions
// Word layouts, message kinds, error codes and sequencer states that are used
// by the controller and the top level.
// ----------------------------------------------------------------------------
package ots_pkg;

	// Operation carried by an input word.
	typedef enum logic {
		OP_UPDATE   = 1'b0,
		OP_SNAPSHOT = 1'b1
	} op_t;

	// Incremental update types.
	typedef enum logic [1:0] {
		UPD_ADD    = 2'd0,
		UPD_MODIFY = 2'd1,
		UPD_CANCEL = 2'd2,
		UPD_OTHER  = 2'd3
	} upd_t;

	// Result message kinds.
	typedef enum logic [2:0] {
		KIND_ACK   = 3'd0,
		KIND_START = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_ORDER = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	// Acknowledgement error codes.
	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_ADD_DUP     = 3'd1,
		ERR_MOD_MISSING = 3'd2,
		ERR_CXL_MISSING = 3'd3,
		ERR_CXL_SIDE    = 3'd4,
		ERR_RANGE       = 3'd5
	} err_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_START,
		S_CLEAR,
		S_SCAN,
		S_EMIT,
		S_END
	} state_t;

	// Input word.
	typedef struct packed {
		logic               op;
		logic [1:0]         update_type;
		logic [1:0]         ticker_id;
		logic [2:0]         order_id;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        qty;
		logic [31:0]        seq_num;
	} in_t;

	// Result word.
	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         snap_index;
		logic [1:0]         out_ticker;
		logic [2:0]         out_order;
		logic               out_side;
		logic signed [31:0] out_price;
		logic [31:0]        out_qty;
		logic [31:0]        seq_value;
		logic [2:0]         error;
		logic               seq_gap;
		logic               last;
	} out_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        qty;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Valid-bit commands from the controller to the slot table.
	typedef struct packed {
		logic set;
		logic clr;
	} vld_cmd_t;

endpackage

[src/ots_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ots_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/ots_ctrl.sv]
// ----------------------------------------------------------------------------
// Order table controller
// Sequencer that applies updates as a read-modify-write of one slot and walks
// the table for snapshots. Keeps the last sequence number.
// ----------------------------------------------------------------------------
module ots_ctrl #(
	parameter int NUM_TICKERS = 4,
	parameter int ORDER_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ots_pkg::in_t          cmd,
	output logic [((NUM_TICKERS * ORDER_SLOTS) > 1 ?
		$clog2(NUM_TICKERS * ORDER_SLOTS) : 1)-1:0] addr,
	input  logic                  slot_valid,
	input  ots_pkg::entry_t       rd_entry,
	output logic                  ram_we,
	output ots_pkg::entry_t       wr_entry,
	output ots_pkg::vld_cmd_t     vld_cmd,
	output logic                  res_strobe,
	output ots_pkg::out_t         res
);

	import ots_pkg::*;

	localparam int DEPTH = NUM_TICKERS * ORDER_SLOTS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int TW    = NUM_TICKERS > 1 ? $clog2(NUM_TICKERS) : 1;
	localparam int OW    = ORDER_SLOTS > 1 ? $clog2(ORDER_SLOTS) : 1;

	state_t       state_q, state_d;
	in_t          req_q;
	logic [31:0]  last_seq_q;
	logic [TW-1:0] tick_q;
	logic [OW-1:0] ord_q;
	logic [5:0]   idx_q;
	logic         last_ord, last_tick, in_range;
	err_t         err;

	// Flat slot index of a ticker and order pair.
	function automatic logic [AW-1:0] slot_of(input logic [2:0] t, input logic [2:0] o);
		return AW'(int'(t) * ORDER_SLOTS + int'(o));
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign last_ord  = (ord_q == OW'(ORDER_SLOTS - 1));
	assign last_tick = (tick_q == TW'(NUM_TICKERS - 1));
	assign in_range  = (int'(req_q.ticker_id) < NUM_TICKERS) &&
		(int'(req_q.order_id) < ORDER_SLOTS);

	// Slot address: the new request on accept, the held request while it is
	// written back, the walk position during a snapshot.
	always_comb begin
		unique case (state_q)
			S_IDLE:   addr = slot_of({1'b0, cmd.ticker_id}, cmd.order_id);
			S_UPDATE: addr = slot_of({1'b0, req_q.ticker_id}, req_q.order_id);
			default:  addr = slot_of(3'(tick_q), 3'(ord_q));
		endcase
	end

	// Update error check against the slot read on accept.
	always_comb begin
		err = ERR_OK;
		if (req_q.update_type != UPD_OTHER) begin
			if (!in_range) begin
				err = ERR_RANGE;
			end else begin
				unique case (req_q.update_type)
					UPD_ADD:    err = slot_valid ? ERR_ADD_DUP : ERR_OK;
					UPD_MODIFY: err = slot_valid ? ERR_OK : ERR_MOD_MISSING;
					default: begin
						if (!slot_valid) begin
							err = ERR_CXL_MISSING;
						end else if (rd_entry.side != req_q.side) begin
							err = ERR_CXL_SIDE;
						end
					end
				endcase
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd.op == OP_SNAPSHOT) ? S_START : S_UPDATE;
				end
			end
			S_UPDATE: state_d = S_IDLE;
			S_START:  state_d = S_CLEAR;
			S_CLEAR:  state_d = S_SCAN;
			S_SCAN: begin
				if (slot_valid) begin
					state_d = S_EMIT;
				end else if (last_ord) begin
					state_d = last_tick ? S_END : S_CLEAR;
				end
			end
			S_EMIT: begin
				if (last_ord) begin
					state_d = last_tick ? S_END : S_CLEAR;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_END:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs: table writes and the result word.
	always_comb begin
		ram_we     = 1'b0;
		wr_entry   = rd_entry;
		vld_cmd    = '0;
		res_strobe = 1'b0;
		res        = '0;
		unique case (state_q)
			S_UPDATE: begin
				res_strobe  = 1'b1;
				res.kind    = KIND_ACK;
				res.error   = err;
				res.seq_gap = (req_q.seq_num != last_seq_q + 32'd1);
				res.last    = 1'b1;
				wr_entry.price = req_q.price;
				wr_entry.qty   = req_q.qty;
				if (err == ERR_OK && req_q.update_type == UPD_ADD) begin
					wr_entry.side = req_q.side;
					ram_we        = 1'b1;
					vld_cmd.set   = 1'b1;
				end else if (err == ERR_OK && req_q.update_type == UPD_MODIFY) begin
					ram_we = 1'b1;
				end else if (err == ERR_OK && req_q.update_type == UPD_CANCEL) begin
					vld_cmd.clr = 1'b1;
				end
			end
			S_START: begin
				res_strobe    = 1'b1;
				res.kind      = KIND_START;
				res.seq_value = last_seq_q;
			end
			S_CLEAR: begin
				res_strobe     = 1'b1;
				res.kind       = KIND_CLEAR;
				res.snap_index = idx_q;
				res.out_ticker = 2'(tick_q);
			end
			S_EMIT: begin
				res_strobe     = 1'b1;
				res.kind       = KIND_ORDER;
				res.snap_index = idx_q;
				res.out_ticker = 2'(tick_q);
				res.out_order  = 3'(ord_q);
				res.out_side   = rd_entry.side;
				res.out_price  = rd_entry.price;
				res.out_qty    = rd_entry.qty;
			end
			S_END: begin
				res_strobe     = 1'b1;
				res.kind       = KIND_END;
				res.snap_index = idx_q;
				res.seq_value  = last_seq_q;
				res.last       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State, sequence number and snapshot walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_seq_q <= '0;
			tick_q     <= '0;
			ord_q      <= '0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_UPDATE) begin
				last_seq_q <= req_q.seq_num;
			end
			if (state_q == S_START) begin
				tick_q <= '0;
				ord_q  <= '0;
				idx_q  <= 6'd1;
			end else if (res_strobe) begin
				idx_q <= idx_q + 6'd1;
			end
			if ((state_q == S_SCAN && !slot_valid) || state_q == S_EMIT) begin
				if (last_ord) begin
					ord_q  <= '0;
					tick_q <= tick_q + TW'(1);
				end else begin
					ord_q <= ord_q + OW'(1);
				end
			end
		end
	end

	// Request capture on accept.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= cmd;
		end
	end

endmodule

[src/order_table_snapshot_builder.sv]
// ----------------------------------------------------------------------------
// Order table snapshot builder
// Mirrors incremental order updates into a per-ticker slot table and publishes
// the whole table as a snapshot message stream on request.
// ----------------------------------------------------------------------------
//
//   channel   handshake            word
//   input     start & !busy        cmd    (ots_pkg::in_t)
//   result    strobe, no stall     result (ots_pkg::out_t)
//
// An update reads the slot on accept and writes it back in the next cycle,
// which also registers the acknowledgement. A snapshot sends a start word,
// then for each ticker a clear word and a visit to every slot of that ticker,
// with an extra step and an order word for each live order, then an end word.
// Reset clears all valid bits and the last sequence number at once; slot
// contents are left as they are. Results leave through an output register.
//
module order_table_snapshot_builder #(
	parameter int NUM_TICKERS = 4,
	parameter int ORDER_SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ots_pkg::in_t  cmd,
	output logic          strobe,
	output ots_pkg::out_t result
);

	import ots_pkg::*;

	localparam int DEPTH = NUM_TICKERS * ORDER_SLOTS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [AW-1:0]    addr;
	logic [DEPTH-1:0] valid_q;
	logic             ram_we;
	entry_t           wr_entry, rd_entry;
	vld_cmd_t         vld_cmd;
	logic             res_strobe;
	out_t             res;

	// Slot contents: side, price and quantity.
	ots_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(wr_entry),
		.raddr(addr),
		.rdata(rd_entry)
	);

	// Sequencer.
	ots_ctrl #(
		.NUM_TICKERS(NUM_TICKERS),
		.ORDER_SLOTS(ORDER_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.addr      (addr),
		.slot_valid(valid_q[addr]),
		.rd_entry  (rd_entry),
		.ram_we    (ram_we),
		.wr_entry  (wr_entry),
		.vld_cmd   (vld_cmd),
		.res_strobe(res_strobe),
		.res       (res)
	);

	// Slot valid bits, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (vld_cmd.set) begin
			valid_q[addr] <= 1'b1;
		end else if (vld_cmd.clr) begin
			valid_q[addr] <= 1'b0;
		end
	end

	// Result strobe register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= res_strobe;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (res_strobe) begin
			result <= res;
		end
	end

endmodule

[tb/sv/ots_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order table snapshot builder: stream checker
// Watches the command and result channels of the block. Every accepted command
// word is applied to a private copy of the order book, and the result words
// it should cause are queued. Each result word is compared field by field with
// the oldest queued word. The failure count goes to the testbench top.
// ----------------------------------------------------------------------------
module ots_stream_checker #(
	parameter int NUM_TICKERS = 4,
	parameter int ORDER_SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  ots_pkg::in_t  cmd,
	input  logic          strobe,
	input  ots_pkg::out_t result,
	input  logic          wrap_up,
	output int            open_count,
	output int            fail_count
);
	import ots_pkg::*;

	localparam int BOOK_SIZE = NUM_TICKERS * ORDER_SLOTS;

	// Private copy of the order book and the last sequence number.
	logic        book_live  [BOOK_SIZE];
	logic        book_side  [BOOK_SIZE];
	logic [31:0] book_price [BOOK_SIZE];
	logic [31:0] book_qty   [BOOK_SIZE];
	logic [31:0] book_seq;

	// Result words still to come, oldest first.
	out_t expected_msgs[$];

	int mismatch_total = 0;
	int result_no = 0;
	bit wrapped = 1'b0;

	// Run statistics for the closing summary.
	int update_total = 0;
	int gap_total = 0;
	int snapshot_total = 0;
	int order_msg_total = 0;
	int longest_snapshot = 0;
	int err_hist [8];

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string what);
		mismatch_total++;
		if (mismatch_total <= 40)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result word %0d, %s: got 0x%0h, expected 0x%0h",
				result_no, name, got, want));
	endtask

	// Apply one command word to the book and queue the words it causes.
	task automatic apply_word(input in_t w);
		out_t msg;
		err_t code;
		int slot;
		int idx;
		if (op_t'(w.op) == OP_UPDATE) begin
			code = ERR_OK;
			if (upd_t'(w.update_type) != UPD_OTHER) begin
				if (int'(w.ticker_id) >= NUM_TICKERS || int'(w.order_id) >= ORDER_SLOTS) begin
					code = ERR_RANGE;
				end else begin
					slot = int'(w.ticker_id) * ORDER_SLOTS + int'(w.order_id);
					case (upd_t'(w.update_type))
						UPD_ADD: begin
							if (book_live[slot]) begin
								code = ERR_ADD_DUP;
							end else begin
								book_live[slot] = 1'b1;
								book_side[slot] = w.side;
								book_price[slot] = w.price;
								book_qty[slot] = w.qty;
							end
						end
						UPD_MODIFY: begin
							if (!book_live[slot]) begin
								code = ERR_MOD_MISSING;
							end else begin
								book_price[slot] = w.price;
								book_qty[slot] = w.qty;
							end
						end
						default: begin
							if (!book_live[slot])
								code = ERR_CXL_MISSING;
							else if (book_side[slot] != w.side)
								code = ERR_CXL_SIDE;
							else
								book_live[slot] = 1'b0;
						end
					endcase
				end
			end
			msg = '0;
			msg.kind = KIND_ACK;
			msg.error = code;
			msg.seq_gap = (w.seq_num != book_seq + 32'd1);
			msg.last = 1'b1;
			// The sequence number is taken even on errors and gaps.
			book_seq = w.seq_num;
			expected_msgs.push_back(msg);
			update_total++;
			err_hist[code]++;
			if (msg.seq_gap)
				gap_total++;
		end else begin
			idx = 0;
			msg = '0;
			msg.kind = KIND_START;
			msg.seq_value = book_seq;
			expected_msgs.push_back(msg);
			idx++;
			for (int t = 0; t < NUM_TICKERS; t++) begin
				msg = '0;
				msg.kind = KIND_CLEAR;
				msg.snap_index = 6'(idx);
				msg.out_ticker = 2'(t);
				expected_msgs.push_back(msg);
				idx++;
				for (int o = 0; o < ORDER_SLOTS; o++) begin
					slot = t * ORDER_SLOTS + o;
					if (book_live[slot]) begin
						msg = '0;
						msg.kind = KIND_ORDER;
						msg.snap_index = 6'(idx);
						msg.out_ticker = 2'(t);
						msg.out_order = 3'(o);
						msg.out_side = book_side[slot];
						msg.out_price = book_price[slot];
						msg.out_qty = book_qty[slot];
						expected_msgs.push_back(msg);
						idx++;
						order_msg_total++;
					end
				end
			end
			msg = '0;
			msg.kind = KIND_END;
			msg.snap_index = 6'(idx);
			msg.seq_value = book_seq;
			msg.last = 1'b1;
			expected_msgs.push_back(msg);
			idx++;
			snapshot_total++;
			if (idx > longest_snapshot)
				longest_snapshot = idx;
		end
	endtask

	task automatic compare_result(input out_t got);
		out_t want;
		if (expected_msgs.size() == 0) begin
			report_mismatch($sformatf("result word %0d (kind %0d) with nothing expected",
				result_no, got.kind));
		end else begin
			want = expected_msgs.pop_front();
			check_field("kind", 32'(got.kind), 32'(want.kind));
			check_field("snap_index", 32'(got.snap_index), 32'(want.snap_index));
			check_field("out_ticker", 32'(got.out_ticker), 32'(want.out_ticker));
			check_field("out_order", 32'(got.out_order), 32'(want.out_order));
			check_field("out_side", 32'(got.out_side), 32'(want.out_side));
			check_field("out_price", got.out_price, want.out_price);
			check_field("out_qty", got.out_qty, want.out_qty);
			check_field("seq_value", got.seq_value, want.seq_value);
			check_field("error", 32'(got.error), 32'(want.error));
			check_field("seq_gap", 32'(got.seq_gap), 32'(want.seq_gap));
			check_field("last", 32'(got.last), 32'(want.last));
		end
		result_no++;
	endtask

	// Results are compared before the word accepted at the same edge is applied.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < BOOK_SIZE; s++)
				book_live[s] = 1'b0;
			book_seq = '0;
			expected_msgs.delete();
			open_count <= 0;
		end else begin
			if (strobe)
				compare_result(result);
			if (start && !busy)
				apply_word(cmd);
			open_count <= expected_msgs.size();
			// Closing check and summary, once the top has drained the block.
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_msgs.size() != 0)
					report_mismatch($sformatf("%0d expected result words never arrived",
						expected_msgs.size()));
				$display("Covered %0d updates (%0d with sequence gaps), %0d snapshots,",
					update_total, gap_total, snapshot_total);
				$display("  %0d order words, longest snapshot %0d words.",
					order_msg_total, longest_snapshot);
				$display("Acks per code: ok %0d, add dup %0d, modify missing %0d,",
					err_hist[ERR_OK], err_hist[ERR_ADD_DUP], err_hist[ERR_MOD_MISSING]);
				$display("  cancel missing %0d, cancel side %0d.",
					err_hist[ERR_CXL_MISSING], err_hist[ERR_CXL_SIDE]);
			end
		end
	end

endmodule

[tb/sv/order_table_snapshot_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order table snapshot builder: testbench top
// Drives a directed list of updates and snapshots through the command port,
// then phases of random order flow that fill, churn and drain the book, with
// random idle gaps and back-to-back stretches. The stream checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module order_table_snapshot_builder_tb;
	import ots_pkg::*;

	localparam int NUM_TICKERS = 4;
	localparam int ORDER_SLOTS = 8;
	localparam int BOOK_SIZE = NUM_TICKERS * ORDER_SLOTS;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	in_t   cmd;
	logic  strobe;
	out_t  result;
	logic  wrap_up;
	int    open_count;
	int    fail_count;

	// Stimulus-side view of which slots hold an order, used to aim updates.
	bit          live_slot [BOOK_SIZE];
	bit          live_side [BOOK_SIZE];
	logic [31:0] seq_head;

	order_table_snapshot_builder #(
		.NUM_TICKERS(NUM_TICKERS),
		.ORDER_SLOTS(ORDER_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	ots_stream_checker #(
		.NUM_TICKERS(NUM_TICKERS),
		.ORDER_SLOTS(ORDER_SLOTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result),
		.wrap_up(wrap_up),
		.open_count(open_count),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Timeout: block stopped responding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_t make_update(input upd_t kind, input int unsigned tick,
			input int unsigned ord, input logic sd, input logic [31:0] px,
			input logic [31:0] amount, input logic [31:0] seq);
		in_t w;
		w.op = OP_UPDATE;
		w.update_type = kind;
		w.ticker_id = 2'(tick);
		w.order_id = 3'(ord);
		w.side = sd;
		w.price = px;
		w.qty = amount;
		w.seq_num = seq;
		return w;
	endfunction

	// Snapshot request with junk in the fields it does not use.
	function automatic in_t make_snapshot();
		in_t w;
		w.op = OP_SNAPSHOT;
		w.update_type = 2'($urandom);
		w.ticker_id = 2'($urandom);
		w.order_id = 3'($urandom);
		w.side = 1'($urandom);
		w.price = $urandom;
		w.qty = $urandom;
		w.seq_num = $urandom;
		return w;
	endfunction

	function automatic logic [31:0] pick_value(input bit is_price);
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return is_price ? 32'h8000_0000 : 32'h0000_0001;
			3: return is_price ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in-order sequence numbers, with repeats and jumps mixed in.
	function automatic logic [31:0] pick_seq();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 88)
			return seq_head + 32'd1;
		else if (roll < 92)
			return seq_head;
		else if (roll < 96)
			return $urandom;
		return seq_head + $urandom_range(2, 5);
	endfunction

	// Random slot that is (or is not) holding an order, -1 if there is none.
	function automatic int pick_slot(input bit want_live);
		int hits[$];
		for (int s = 0; s < BOOK_SIZE; s++)
			if (live_slot[s] == want_live)
				hits.push_back(s);
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	function automatic in_t random_update(input int add_pct, input int mod_pct);
		int roll;
		int s;
		upd_t kind;
		logic sd;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			kind = UPD_OTHER;
		else if (roll < 5 + add_pct)
			kind = UPD_ADD;
		else if (roll < 5 + add_pct + mod_pct)
			kind = UPD_MODIFY;
		else
			kind = UPD_CANCEL;
		s = -1;
		// Most updates are aimed so that they succeed.
		if ($urandom_range(0, 99) < 85) begin
			case (kind)
				UPD_ADD: s = pick_slot(1'b0);
				UPD_MODIFY, UPD_CANCEL: s = pick_slot(1'b1);
				default: s = -1;
			endcase
		end
		sd = 1'($urandom);
		if (s >= 0 && kind == UPD_CANCEL)
			sd = ($urandom_range(0, 99) < 90) ? live_side[s] : !live_side[s];
		if (s >= 0)
			return make_update(kind, s / ORDER_SLOTS, s % ORDER_SLOTS, sd,
				pick_value(1'b1), pick_value(1'b0), pick_seq());
		return make_update(kind, $urandom_range(0, 3), $urandom_range(0, 7), sd,
			pick_value(1'b1), pick_value(1'b0), pick_seq());
	endfunction

	// Track what a word does to the book, for aiming later updates.
	task automatic note_word(input in_t w);
		int s;
		if (op_t'(w.op) == OP_UPDATE) begin
			seq_head = w.seq_num;
			s = int'(w.ticker_id) * ORDER_SLOTS + int'(w.order_id);
			if (s < BOOK_SIZE) begin
				if (upd_t'(w.update_type) == UPD_ADD && !live_slot[s]) begin
					live_slot[s] = 1'b1;
					live_side[s] = w.side;
				end else if (upd_t'(w.update_type) == UPD_CANCEL && live_slot[s]
						&& live_side[s] == w.side) begin
					live_slot[s] = 1'b0;
				end
			end
		end
	endtask

	// Present one word, wait for it to be taken, then idle for the gap.
	task automatic send_word(input in_t w, input int unsigned gap);
		cmd <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		note_word(w);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every expected result word has come back.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (open_count != 0);
	endtask

	initial begin
		int add_pct;
		int mod_pct;
		in_t w;

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		wrap_up <= 1'b0;
		seq_head = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty book, price and quantity extremes, every error code but
		// ERR_RANGE, other type, sequence gaps and the sequence wrap.
		send_word(make_snapshot(), pick_gap());
		send_word(make_update(UPD_ADD, 0, 0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1), 0);
		send_word(make_update(UPD_ADD, 3, 7, 1'b1, 32'h8000_0000, 32'd0, 32'd2), 0);
		send_word(make_update(UPD_ADD, 0, 0, 1'b1, 32'd5, 32'd5, 32'd3), pick_gap());
		send_word(make_update(UPD_MODIFY, 1, 2, 1'b0, 32'd9, 32'd9, 32'd4), pick_gap());
		send_word(make_update(UPD_MODIFY, 0, 0, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd5), 0);
		send_word(make_update(UPD_CANCEL, 2, 5, 1'b0, 32'd0, 32'd0, 32'd6), pick_gap());
		send_word(make_update(UPD_CANCEL, 3, 7, 1'b0, 32'd0, 32'd0, 32'd7), 0);
		send_word(make_update(UPD_OTHER, 0, 0, 1'b1, 32'd3, 32'd3, 32'd8), pick_gap());
		send_word(make_snapshot(), 0);
		send_word(make_update(UPD_CANCEL, 3, 7, 1'b1, 32'd0, 32'd0, 32'd9), pick_gap());
		send_word(make_update(UPD_ADD, 1, 3, 1'b1, 32'd0, 32'h8000_0000, 32'd100), 0);
		send_word(make_update(UPD_OTHER, 3, 7, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF), pick_gap());
		send_word(make_update(UPD_ADD, 2, 4, 1'b0, 32'd1, 32'd7, 32'd0), 0);
		send_word(make_update(UPD_MODIFY, 2, 4, 1'b0, 32'h8000_0001, 32'd2, 32'd0), pick_gap());
		send_word(make_snapshot(), pick_gap());
		drain_results();

		// Random phases: fill, churn, drain, twice over. The middle phase of
		// each round runs back to back.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 3)
				0: begin
					add_pct = 70;
					mod_pct = 15;
				end
				1: begin
					add_pct = 30;
					mod_pct = 35;
				end
				default: begin
					add_pct = 10;
					mod_pct = 25;
				end
			endcase
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(0, 99) < 8)
					w = make_snapshot();
				else
					w = random_update(add_pct, mod_pct);
				send_word(w, (phase % 3 == 1) ? 0 : pick_gap());
			end
			if (phase % 3 == 0)
				drain_results();
		end

		// Let the last words come out, then allow for stray extra words.
		drain_results();
		repeat (100) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
src/ots_pkg.sv
src/ots_ram.sv
src/ots_ctrl.sv
src/order_table_snapshot_builder.sv
tb/sv/ots_stream_checker.sv
tb/sv/order_table_snapshot_builder_tb.sv
